// ===== rtl/gfau_pkg.sv =====
package gfau_pkg;

  localparam int MAX_FIELD_BITS = 8;
  localparam int ELEM_W = 8;
  localparam int EXP_W = 16;
  localparam int POLY_W = 9;
  localparam int FB_W = 4;
  localparam int LOG_DEPTH = 256;

  localparam logic [2:0] REQ_ADD = 3'd0;
  localparam logic [2:0] REQ_SUB = 3'd1;
  localparam logic [2:0] REQ_MUL = 3'd2;
  localparam logic [2:0] REQ_DIV = 3'd3;
  localparam logic [2:0] REQ_POW = 3'd4;

  localparam logic [1:0] ERR_OK = 2'd0;
  localparam logic [1:0] ERR_RANGE = 2'd1;
  localparam logic [1:0] ERR_DIVZ = 2'd2;
  localparam logic [1:0] ERR_BADREQ = 2'd3;

  // How the last stage combines the power result with the carried operand.
  typedef enum logic [1:0] {
    FIN_XOR,
    FIN_MUL,
    FIN_POW
  } fin_t;

  // Field degree clamped to the supported range.
  function automatic logic [FB_W-1:0] eff_bits(input logic [FB_W-1:0] fb);
    logic [FB_W-1:0] m;
    m = fb;
    if (m < FB_W'(2)) m = FB_W'(2);
    if (m > FB_W'(MAX_FIELD_BITS)) m = FB_W'(MAX_FIELD_BITS);
    return m;
  endfunction

  // Polynomial with the x^m term forced and higher terms dropped.
  function automatic logic [POLY_W-1:0] full_poly(input logic [POLY_W-1:0] fp,
                                                  input logic [FB_W-1:0] m);
    logic [POLY_W-1:0] top;
    top = POLY_W'(1) << m;
    return (fp & (top - POLY_W'(1))) | top;
  endfunction

  // Shift-and-add multiply with reduction, one bit per step.
  function automatic logic [ELEM_W-1:0] gmul(input logic [ELEM_W-1:0] a,
                                             input logic [ELEM_W-1:0] b,
                                             input logic [FB_W-1:0] m,
                                             input logic [POLY_W-1:0] poly);
    logic [POLY_W-1:0] aa;
    logic [POLY_W-1:0] acc;
    aa = POLY_W'(a);
    acc = '0;
    for (int i = 0; i < MAX_FIELD_BITS; i++) begin
      if (FB_W'(i) < m) begin
        if (b[i]) acc = acc ^ aa;
        aa = aa << 1;
        if (aa[m]) aa = aa ^ poly;
      end
    end
    return acc[ELEM_W-1:0];
  endfunction

endpackage

// ===== rtl/gfau_req_if.sv =====
interface gfau_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  operand_a;
  logic [7:0]  operand_b;
  logic [15:0] exponent;

  modport source(output valid, req_type, operand_a, operand_b, exponent, input ready);
  modport sink(input valid, req_type, operand_a, operand_b, exponent, output ready);
endinterface

// ===== rtl/gfau_rsp_if.sv =====
interface gfau_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] result;
  logic [7:0] result_log;
  logic       result_is_zero;
  logic [1:0] error;

  modport source(output valid, result, result_log, result_is_zero, error, input ready);
  modport sink(input valid, result, result_log, result_is_zero, error, output ready);
endinterface

// ===== rtl/gf2m_arithmetic_unit.sv =====
// GF(2^m) arithmetic unit.
// Requests arrive on the req channel (valid/ready) and each produces exactly one
// transaction on the rsp channel, in order. Add and subtract are XOR, multiply is
// a carry-less product reduced by the configured polynomial, divide multiplies by
// b^(2^m-2), and power is square-and-multiply over the 16 exponent bits.
// Every result carries its discrete log, read from a 256-entry log memory.
// The datapath is a 19-stage pipeline, and one request can be accepted every cycle
// while the log memory is not being rebuilt and the receiver is not stalling.
// The field degree and polynomial sit on an APB port (index 0 at address 0,
// index 1 at address 4); write them only while no request is in flight.
// After reset and after each configuration write the log memory is rebuilt by
// walking x^k, one entry per cycle, and req.ready stays low until the walk ends.
// Unreached entries read as log 0.
// When the receiver stalls, the whole pipeline holds, and req.ready drops
// in the same cycle, so no transaction is lost or repeated.
module gf2m_arithmetic_unit
  import gfau_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  gfau_req_if.sink    req,
  gfau_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [FB_W-1:0]   field_bits;
  logic [POLY_W-1:0] field_polynomial;
  logic [FB_W-1:0]   m_eff;
  logic [POLY_W-1:0] poly;
  logic [ELEM_W-1:0] n_elems;
  logic              cfg_wr;

  assign m_eff = eff_bits(field_bits);
  assign poly = full_poly(field_polynomial, m_eff);
  assign n_elems = ELEM_W'((POLY_W'(1) << m_eff) - POLY_W'(1));
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {23'd0, field_polynomial} : {28'd0, field_bits};

  // Log table rebuild: walk x^k and record the first k that reaches each value.
  logic                 busy;
  logic [ELEM_W-1:0]    bx;
  logic [ELEM_W-1:0]    bk;
  logic [LOG_DEPTH-1:0] seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_bits <= FB_W'(8);
      field_polynomial <= POLY_W'(285);
      busy <= 1'b1;
      bx <= ELEM_W'(1);
      bk <= '0;
      seen <= '0;
    end else if (cfg_wr) begin
      if (paddr[2]) field_polynomial <= pwdata[POLY_W-1:0];
      else field_bits <= pwdata[FB_W-1:0];
      busy <= 1'b1;
      bx <= ELEM_W'(1);
      bk <= '0;
      seen <= '0;
    end else if (busy) begin
      seen[bx] <= 1'b1;
      bx <= gmul(bx, ELEM_W'(2), m_eff, poly);
      bk <= bk + ELEM_W'(1);
      if (bk == n_elems - ELEM_W'(1)) busy <= 1'b0;
    end
  end

  // Pipeline control: everything advances together unless the output is stuck.
  logic en;
  assign en = !rsp.valid || rsp.ready;
  assign req.ready = en && !busy;

  // Stage 0 decode.
  logic [1:0]        d_err;
  logic [ELEM_W-1:0] d_base;
  logic [EXP_W-1:0]  d_exp;
  logic [ELEM_W-1:0] d_a;
  fin_t              d_fin;

  always_comb begin
    d_base = req.operand_b;
    d_exp = '0;
    d_a = req.operand_a;
    d_fin = FIN_POW;
    if (req.req_type > REQ_POW) d_err = ERR_BADREQ;
    else if ((req.operand_a >> m_eff) != '0 ||
             (req.req_type != REQ_POW && (req.operand_b >> m_eff) != '0)) d_err = ERR_RANGE;
    else if (req.req_type == REQ_DIV && req.operand_b == '0) d_err = ERR_DIVZ;
    else d_err = ERR_OK;
    priority if (req.req_type == REQ_ADD || req.req_type == REQ_SUB) begin
      d_a = req.operand_a ^ req.operand_b;
      d_fin = FIN_XOR;
    end else if (req.req_type == REQ_MUL) begin
      d_exp = EXP_W'(1);
      d_fin = FIN_MUL;
    end else if (req.req_type == REQ_DIV) begin
      d_exp = EXP_W'((POLY_W'(1) << m_eff) - POLY_W'(2));
      d_fin = FIN_MUL;
    end else begin
      d_base = req.operand_a;
      d_exp = req.exponent;
    end
  end

  // Power stages: stage j+1 handles exponent bit j.
  logic              p_v    [EXP_W+1];
  logic [ELEM_W-1:0] p_r    [EXP_W+1];
  logic [ELEM_W-1:0] p_base [EXP_W+1];
  logic [EXP_W-1:0]  p_exp  [EXP_W+1];
  logic [ELEM_W-1:0] p_a    [EXP_W+1];
  fin_t              p_fin  [EXP_W+1];
  logic [1:0]        p_err  [EXP_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= EXP_W; j++) p_v[j] <= 1'b0;
    end else if (en) begin
      p_v[0] <= req.valid && req.ready;
      for (int j = 0; j < EXP_W; j++) p_v[j+1] <= p_v[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= ELEM_W'(1);
      p_base[0] <= d_base;
      p_exp[0] <= d_exp;
      p_a[0] <= d_a;
      p_fin[0] <= d_fin;
      p_err[0] <= d_err;
      for (int j = 0; j < EXP_W; j++) begin
        p_r[j+1] <= p_exp[j][j] ? gmul(p_r[j], p_base[j], m_eff, poly) : p_r[j];
        p_base[j+1] <= gmul(p_base[j], p_base[j], m_eff, poly);
        p_exp[j+1] <= p_exp[j];
        p_a[j+1] <= p_a[j];
        p_fin[j+1] <= p_fin[j];
        p_err[j+1] <= p_err[j];
      end
    end
  end

  // Final combine stage.
  logic              f_v;
  logic [ELEM_W-1:0] f_res;
  logic [1:0]        f_err;
  logic [ELEM_W-1:0] f_next;

  always_comb begin
    unique case (p_fin[EXP_W])
      FIN_XOR: f_next = p_a[EXP_W];
      FIN_MUL: f_next = gmul(p_a[EXP_W], p_r[EXP_W], m_eff, poly);
      default: f_next = p_r[EXP_W];
    endcase
    if (p_err[EXP_W] != ERR_OK) f_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) f_v <= 1'b0;
    else if (en) f_v <= p_v[EXP_W];
    if (en) begin
      f_res <= f_next;
      f_err <= p_err[EXP_W];
    end
  end

  // Output stage: log memory read lines up with the registered result.
  logic              o_v;
  logic [ELEM_W-1:0] o_res;
  logic [1:0]        o_err;
  logic              o_seen;
  logic [ELEM_W-1:0] log_rd;

  gfau_ram #(.WIDTH(ELEM_W), .DEPTH(LOG_DEPTH)) u_log_ram (
    .clk  (clk),
    .we   (busy && !seen[bx]),
    .waddr(bx),
    .wdata(bk),
    .re   (en),
    .raddr(f_res),
    .rdata(log_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) o_v <= 1'b0;
    else if (en) o_v <= f_v;
    if (en) begin
      o_res <= f_res;
      o_err <= f_err;
      o_seen <= seen[f_res];
    end
  end

  assign rsp.valid = o_v;
  assign rsp.result = o_res;
  assign rsp.result_is_zero = (o_res == '0);
  assign rsp.result_log = (o_seen && o_res != '0) ? log_rd : '0;
  assign rsp.error = o_err;

  a_busy_blocks: assert property (@(posedge clk) busy |-> !req.ready)
    else $error("request accepted during log table rebuild");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.error != ERR_OK |-> rsp.result == '0)
    else $error("error response carries a nonzero result");
  a_rebuild_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(cfg_wr) || $past(rst))
    else $error("log table rebuild started without a configuration write");

endmodule

// ===== rtl/gfau_ram.sv =====
module gfau_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
